/* hw/rtl/adto_pkg.sv */
package adto_pkg;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_ENGINE_MODE      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP_SCALE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CHANGE_THRESHOLD = 2'd2;

    localparam int HEADING_W = 13;
    localparam int SAMPLE_W  = 16;

    // Input transaction: one audio frame
    typedef struct packed {
        logic [HEADING_W-1:0] heading;
        logic                 buffer_start;
    } frame_item_t;

    // Output transaction: one stereo sample pair
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_sample;
        logic signed [SAMPLE_W-1:0] right_sample;
    } sample_item_t;

    // Per-channel lookup control handed to the sine table
    typedef struct packed {
        logic negate;
        logic mute;
    } tap_ctl_t;

endpackage

/* hw/rtl/adto_frame_if.sv */
interface adto_frame_if;
    import adto_pkg::*;

    logic        valid;
    logic        ready;
    frame_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/adto_sample_if.sv */
interface adto_sample_if;
    import adto_pkg::*;

    logic         valid;
    logic         ready;
    sample_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/adto_sine_rom.sv */
module adto_sine_rom #(
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic                                 clk,
    input  logic                                 en,
    input  logic [$clog2(SINE_TABLE_DEPTH):0]    left_idx,
    input  adto_pkg::tap_ctl_t                   left_ctl,
    input  logic [$clog2(SINE_TABLE_DEPTH):0]    right_idx,
    input  adto_pkg::tap_ctl_t                   right_ctl,
    output logic signed [adto_pkg::SAMPLE_W-1:0] left_sample,
    output logic signed [adto_pkg::SAMPLE_W-1:0] right_sample
);
    import adto_pkg::*;

    localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] FULL_SCALE  = 64'd32767;

    typedef logic [SAMPLE_W-1:0] rom_t [0:SINE_TABLE_DEPTH];

    // Quarter-wave table: Q30 Taylor sine, Horner form, truncating steps
    function automatic rom_t build_rom();
        rom_t        r;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        for (int i = 0; i <= SINE_TABLE_DEPTH; i++)
        begin
            x  = (HALF_PI_Q30 * 64'(i)) / SINE_TABLE_DEPTH;
            x2 = (x * x) >> 30;
            t  = Q30_ONE - x2 / 110;
            t  = Q30_ONE - ((x2 * t) >> 30) / 72;
            t  = Q30_ONE - ((x2 * t) >> 30) / 42;
            t  = Q30_ONE - ((x2 * t) >> 30) / 20;
            t  = Q30_ONE - ((x2 * t) >> 30) / 6;
            s  = (x * t) >> 30;
            if (s > Q30_ONE)
            begin
                s = Q30_ONE;
            end
            r[i] = SAMPLE_W'((FULL_SCALE * s) >> 30);
        end
        return r;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    logic signed [SAMPLE_W-1:0] left_raw;
    logic signed [SAMPLE_W-1:0] right_raw;

    assign left_raw  = SINE_ROM[left_idx];
    assign right_raw = SINE_ROM[right_idx];

    // Read both taps, apply quadrant sign and mute into the result register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            left_sample  <= left_ctl.mute ? '0 : (left_ctl.negate ? -left_raw : left_raw);
            right_sample <= right_ctl.mute ? '0 : (right_ctl.negate ? -right_raw : right_raw);
        end
    end

endmodule

/* hw/rtl/azimuth_dual_tone_oscillator.sv */
// An accepted frame transaction passes the lookup register, then the sine table
//   read into the result register, before its result appears.
// Throughput: one frame per cycle unless sample_out stalls; phases update on accept.
// Reset (rst_n low, asynchronous): phases, quiet heading and tone flag clear,
//   registers return to dual-tone mode, scale 22906492, threshold 16.
module azimuth_dual_tone_oscillator #(
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int PHASE_BITS       = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [adto_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [adto_pkg::CFG_DATA_W-1:0]     cfg_data,
    adto_frame_if.sink                          frame_in,
    adto_sample_if.source                       sample_out
);
    import adto_pkg::*;

    localparam int ADDR_W = $clog2(SINE_TABLE_DEPTH);
    localparam int IDX_W  = ADDR_W + 1;
    localparam int FREQ_W = 13;
    localparam int PROD_W = FREQ_W + 32;

    localparam logic [HEADING_W-1:0] HEADING_FULL = 13'd5760;
    localparam logic [HEADING_W-1:0] HEADING_HALF = 13'd2880;
    localparam logic [FREQ_W-1:0]    LEFT_BASE    = 13'd3520;
    localparam logic [FREQ_W-1:0]    RIGHT_BASE   = 13'd4960;
    localparam logic [FREQ_W-1:0]    TEST_FREQ    = 13'd3520;

    // Configuration registers
    logic                 engine_mode_reg;
    logic [31:0]          phase_step_scale_reg;
    logic [HEADING_W-1:0] change_threshold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            engine_mode_reg      <= 1'b0;
            phase_step_scale_reg <= 32'd22906492;
            change_threshold_reg <= 13'd16;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ENGINE_MODE:      engine_mode_reg      <= cfg_data[0];
                REG_PHASE_STEP_SCALE: phase_step_scale_reg <= cfg_data[31:0];
                REG_CHANGE_THRESHOLD: change_threshold_reg <= cfg_data[HEADING_W-1:0];
                default:              ;
            endcase
        end
    end

    // Pipeline flow control
    logic s1_valid_reg;
    logic out_valid_reg;
    logic adv_out;
    logic adv_s1;
    logic in_acc;

    assign adv_out          = !out_valid_reg || sample_out.ready;
    assign adv_s1           = !s1_valid_reg || adv_out;
    assign frame_in.ready   = adv_s1;
    assign in_acc           = frame_in.valid && adv_s1;
    assign sample_out.valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv_s1)
            begin
                s1_valid_reg <= in_acc;
            end
            if (adv_out)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Oscillator state
    logic [PHASE_BITS-1:0] left_phase_reg;
    logic [PHASE_BITS-1:0] right_phase_reg;
    logic [HEADING_W-1:0]  quiet_heading_reg;
    logic                  tone_on_reg;

    logic [PHASE_BITS-1:0] left_phase_next;
    logic [PHASE_BITS-1:0] right_phase_next;
    logic [HEADING_W-1:0]  quiet_heading_next;
    logic                  tone_on_next;

    // Phase increment: (freq * scale) scaled to the accumulator width
    function automatic logic [PHASE_BITS-1:0] step_of(
        input logic [FREQ_W-1:0] freq,
        input logic [31:0]       scale
    );
        logic [PROD_W-1:0]            prod;
        logic [PROD_W+PHASE_BITS-1:0] wide;
        prod = PROD_W'(freq) * PROD_W'(scale);
        wide = (PROD_W + PHASE_BITS)'(prod) << PHASE_BITS;
        return wide[PHASE_BITS+42 -: PHASE_BITS];
    endfunction

    // Fold the saturated heading to 0..180 degrees
    logic [HEADING_W-1:0] heading_sat;
    logic [HEADING_W-1:0] fold;
    logic [FREQ_W-1:0]    left_freq;
    logic [FREQ_W-1:0]    right_freq;

    always_comb
    begin
        heading_sat = (frame_in.data.heading > HEADING_FULL) ? HEADING_FULL
                                                             : frame_in.data.heading;
        fold        = (heading_sat > HEADING_HALF) ? (HEADING_FULL - heading_sat) : heading_sat;
        left_freq   = engine_mode_reg ? TEST_FREQ : (LEFT_BASE + fold);
        right_freq  = RIGHT_BASE - fold;
    end

    // Latency test: compare heading against quiet heading plus or minus threshold
    logic [HEADING_W:0] upper_bound;
    logic [HEADING_W:0] heading_plus_th;
    logic               moved;

    always_comb
    begin
        upper_bound     = (HEADING_W+1)'(quiet_heading_reg) + (HEADING_W+1)'(change_threshold_reg);
        heading_plus_th = (HEADING_W+1)'(frame_in.data.heading)
                        + (HEADING_W+1)'(change_threshold_reg);
        moved           = ((HEADING_W+1)'(frame_in.data.heading) > upper_bound)
                       || (heading_plus_th < (HEADING_W+1)'(quiet_heading_reg));
    end

    // Next state for the accepted frame
    always_comb
    begin
        left_phase_next    = left_phase_reg;
        right_phase_next   = right_phase_reg;
        quiet_heading_next = quiet_heading_reg;
        tone_on_next       = tone_on_reg;
        if (in_acc)
        begin
            left_phase_next = left_phase_reg + step_of(left_freq, phase_step_scale_reg);
            if (!engine_mode_reg)
            begin
                right_phase_next = right_phase_reg + step_of(right_freq, phase_step_scale_reg);
            end
            else if (frame_in.data.buffer_start)
            begin
                tone_on_next = moved;
                if (moved)
                begin
                    quiet_heading_next = frame_in.data.heading;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_phase_reg    <= '0;
            right_phase_reg   <= '0;
            quiet_heading_reg <= '0;
            tone_on_reg       <= 1'b0;
        end
        else
        begin
            left_phase_reg    <= left_phase_next;
            right_phase_reg   <= right_phase_next;
            quiet_heading_reg <= quiet_heading_next;
            tone_on_reg       <= tone_on_next;
        end
    end

    // Map a phase to a quarter-wave index; odd quadrants read mirrored
    function automatic logic [IDX_W-1:0] index_of(input logic [PHASE_BITS-1:0] ph);
        logic [ADDR_W-1:0] k;
        k = ph[PHASE_BITS-3 -: ADDR_W];
        return ph[PHASE_BITS-2] ? (IDX_W'(SINE_TABLE_DEPTH) - IDX_W'(k)) : IDX_W'(k);
    endfunction

    // Lookup register: sample uses the phase before this frame's advance
    logic [IDX_W-1:0] left_idx_reg;
    logic [IDX_W-1:0] right_idx_reg;
    tap_ctl_t         left_ctl_reg;
    tap_ctl_t         right_ctl_reg;

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            left_idx_reg        <= index_of(left_phase_reg);
            left_ctl_reg.negate <= left_phase_reg[PHASE_BITS-1];
            left_ctl_reg.mute   <= engine_mode_reg && !tone_on_next;
            if (engine_mode_reg)
            begin
                right_idx_reg        <= index_of(left_phase_reg);
                right_ctl_reg.negate <= left_phase_reg[PHASE_BITS-1];
                right_ctl_reg.mute   <= !tone_on_next;
            end
            else
            begin
                right_idx_reg        <= index_of(right_phase_reg);
                right_ctl_reg.negate <= right_phase_reg[PHASE_BITS-1];
                right_ctl_reg.mute   <= 1'b0;
            end
        end
    end

    // Table read into the result register
    adto_sine_rom #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_sine_rom (
        .clk          (clk),
        .en           (adv_out && s1_valid_reg),
        .left_idx     (left_idx_reg),
        .left_ctl     (left_ctl_reg),
        .right_idx    (right_idx_reg),
        .right_ctl    (right_ctl_reg),
        .left_sample  (sample_out.data.left_sample),
        .right_sample (sample_out.data.right_sample)
    );

    // Checks
    a_test_right_phase_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && engine_mode_reg) |=> $stable(right_phase_reg))
        else $error("right phase moved in latency-test mode");

    a_test_channels_match: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && engine_mode_reg)
            |-> (sample_out.data.left_sample == sample_out.data.right_sample))
        else $error("latency-test channels differ");

    a_quiet_only_on_start: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_acc && engine_mode_reg && frame_in.data.buffer_start)
            |=> $stable(quiet_heading_reg))
        else $error("quiet heading changed outside a test-mode buffer start");

endmodule
